### hw/rtl/twrs_pkg.sv
// Package for the toroidal wrap rectangle splitter.
// Holds the request and piece payload types and the internal arithmetic width.
// No dependencies.
`timescale 1ns / 1ps

package twrs_pkg;

    // Width of the exact texture-space arithmetic.
    // It covers edge - low + origin and the following size subtract with no overflow.
    localparam int WIDE_W = 36;

    typedef logic signed [WIDE_W-1:0] twrs_wide_t;

    // One update request.
    typedef struct packed {
        logic [4:0]         level_id;
        logic signed [31:0] upd_west;
        logic signed [31:0] upd_south;
        logic signed [31:0] upd_east;
        logic signed [31:0] upd_north;
        logic signed [31:0] ext_west;
        logic signed [31:0] ext_south;
        logic signed [31:0] ext_east;
        logic signed [31:0] ext_north;
        logic [11:0]        origin_x;
        logic [11:0]        origin_y;
    } twrs_req_t;

    // One non-wrapping piece.
    typedef struct packed {
        logic [4:0]         piece_level;
        logic signed [31:0] piece_west;
        logic signed [31:0] piece_south;
        logic signed [31:0] piece_east;
        logic signed [31:0] piece_north;
        logic               piece_last;
    } twrs_piece_t;

endpackage

### hw/rtl/toroidal_wrap_rect_split_unit.sv
// Top level of the toroidal wrap rectangle splitter.
// Depends on twrs_pkg for the request and piece types.
`timescale 1ns / 1ps

// Splits one update rectangle into one, two or four non-wrapping pieces.
// A request is taken when start is high and busy is low. Each piece shows
// on the piece port for one cycle with piece_valid high, and the receiver
// cannot stall it. An update that does not wrap yields one piece, an update
// that wraps in one direction yields two, and one that wraps in both yields
// four. The piece sequencer emits one piece per cycle, and that sets the rate.
// Two register stages sit in front of the sequencer (input, offsets), and the
// sequencer register holds the mapped compare; the output register follows.
// While the sequencer works through a wrapping update, the offsets stage holds
// its contents and the input stage moves forward only into an empty offsets
// stage. busy rises only when the input stage is occupied and cannot move
// forward.
module toroidal_wrap_rect_split_unit
    import twrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  twrs_req_t   req,
    output logic        piece_valid,
    output twrs_piece_t piece
);

    // Stage 1: the registered request.
    logic      s1_valid_reg;
    twrs_req_t s1_reg;

    // Stage 2: offsets in texture space, extent sizes and seam posts.
    typedef struct packed {
        logic [4:0]         level;
        logic signed [31:0] uw;
        logic signed [31:0] us;
        logic signed [31:0] ue;
        logic signed [31:0] un;
        twrs_wide_t         tw;
        twrs_wide_t         te;
        twrs_wide_t         ts;
        twrs_wide_t         tn;
        twrs_wide_t         size_x;
        twrs_wide_t         size_y;
        logic signed [31:0] seam_x_lo;
        logic signed [31:0] seam_x_hi;
        logic signed [31:0] seam_y_lo;
        logic signed [31:0] seam_y_hi;
    } twrs_ofs_t;

    logic      s2_valid_reg;
    twrs_ofs_t s2_reg;
    twrs_ofs_t s2_next;

    // Stage 3: the piece sequencer.
    typedef struct packed {
        logic [4:0]         level;
        logic signed [31:0] uw;
        logic signed [31:0] us;
        logic signed [31:0] ue;
        logic signed [31:0] un;
        logic signed [31:0] seam_x_lo;
        logic signed [31:0] seam_x_hi;
        logic signed [31:0] seam_y_lo;
        logic signed [31:0] seam_y_hi;
        logic               wrap_x;
        logic               wrap_y;
    } twrs_seq_t;

    logic      s3_valid_reg;
    twrs_seq_t s3_reg;
    twrs_seq_t s3_next;
    logic [1:0] idx_reg;

    // Output register.
    logic        piece_valid_reg;
    twrs_piece_t piece_reg;
    twrs_piece_t piece_next;

    // Pipeline flow control.
    logic [1:0] last_idx;
    logic       s3_last;
    logic       s3_free;
    logic       s3_load;
    logic       s2_load;
    logic       s1_load;
    logic       s1_free;
    logic       s2_free;

    // Conditional subtract that reduces a texture offset into the extent.
    function automatic twrs_wide_t wrap_reduce(twrs_wide_t t, twrs_wide_t size);
        twrs_wide_t r;
        r = t - size;
        return (t >= size) ? r : t;
    endfunction

    // Index of the final piece for the current wrap case.
    always_comb
    begin
        if (s3_reg.wrap_x && s3_reg.wrap_y)
        begin
            last_idx = 2'd3;
        end
        else if (s3_reg.wrap_x || s3_reg.wrap_y)
        begin
            last_idx = 2'd1;
        end
        else
        begin
            last_idx = 2'd0;
        end
    end

    assign s3_last = s3_valid_reg && (idx_reg == last_idx);
    assign s3_free = !s3_valid_reg || s3_last;
    assign s3_load = s2_valid_reg && s3_free;
    assign s2_free = !s2_valid_reg || s3_load;
    assign s2_load = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s2_load;
    assign s1_load = start && s1_free;
    assign busy    = !s1_free;

    // Offsets from the extent's low edge, sizes and seam posts.
    always_comb
    begin
        twrs_wide_t ox;
        twrs_wide_t oy;
        twrs_wide_t ew;
        twrs_wide_t es;
        twrs_wide_t ee;
        twrs_wide_t en;
        ox = twrs_wide_t'({{(WIDE_W-12){1'b0}}, s1_reg.origin_x});
        oy = twrs_wide_t'({{(WIDE_W-12){1'b0}}, s1_reg.origin_y});
        ew = twrs_wide_t'({{(WIDE_W-32){s1_reg.ext_west[31]}}, s1_reg.ext_west});
        es = twrs_wide_t'({{(WIDE_W-32){s1_reg.ext_south[31]}}, s1_reg.ext_south});
        ee = twrs_wide_t'({{(WIDE_W-32){s1_reg.ext_east[31]}}, s1_reg.ext_east});
        en = twrs_wide_t'({{(WIDE_W-32){s1_reg.ext_north[31]}}, s1_reg.ext_north});

        s2_next.level  = s1_reg.level_id;
        s2_next.uw     = s1_reg.upd_west;
        s2_next.us     = s1_reg.upd_south;
        s2_next.ue     = s1_reg.upd_east;
        s2_next.un     = s1_reg.upd_north;
        s2_next.tw     = ox - ew +
                         twrs_wide_t'({{(WIDE_W-32){s1_reg.upd_west[31]}}, s1_reg.upd_west});
        s2_next.te     = ox - ew +
                         twrs_wide_t'({{(WIDE_W-32){s1_reg.upd_east[31]}}, s1_reg.upd_east});
        s2_next.ts     = oy - es +
                         twrs_wide_t'({{(WIDE_W-32){s1_reg.upd_south[31]}}, s1_reg.upd_south});
        s2_next.tn     = oy - es +
                         twrs_wide_t'({{(WIDE_W-32){s1_reg.upd_north[31]}}, s1_reg.upd_north});
        s2_next.size_x = ee - ew + twrs_wide_t'(1);
        s2_next.size_y = en - es + twrs_wide_t'(1);

        // Seam posts wrap modulo 2^32 like the piece fields.
        s2_next.seam_x_lo = s1_reg.ext_east - signed'({20'd0, s1_reg.origin_x});
        s2_next.seam_x_hi = s1_reg.ext_east - signed'({20'd0, s1_reg.origin_x}) + 32'sd1;
        s2_next.seam_y_lo = s1_reg.ext_north - signed'({20'd0, s1_reg.origin_y});
        s2_next.seam_y_hi = s1_reg.ext_north - signed'({20'd0, s1_reg.origin_y}) + 32'sd1;
    end

    // Reduction into the extent and the wrap decision.
    always_comb
    begin
        twrs_wide_t mw;
        twrs_wide_t me;
        twrs_wide_t ms;
        twrs_wide_t mn;
        mw = wrap_reduce(s2_reg.tw, s2_reg.size_x);
        me = wrap_reduce(s2_reg.te, s2_reg.size_x);
        ms = wrap_reduce(s2_reg.ts, s2_reg.size_y);
        mn = wrap_reduce(s2_reg.tn, s2_reg.size_y);

        s3_next.level     = s2_reg.level;
        s3_next.uw        = s2_reg.uw;
        s3_next.us        = s2_reg.us;
        s3_next.ue        = s2_reg.ue;
        s3_next.un        = s2_reg.un;
        s3_next.seam_x_lo = s2_reg.seam_x_lo;
        s3_next.seam_x_hi = s2_reg.seam_x_hi;
        s3_next.seam_y_lo = s2_reg.seam_y_lo;
        s3_next.seam_y_hi = s2_reg.seam_y_hi;
        s3_next.wrap_x    = me < mw;
        s3_next.wrap_y    = mn < ms;
    end

    // Piece selection: bit 0 of the index picks the right half when wrapping in x;
    // the top half comes from bit 1 with both wraps, else from bit 0.
    always_comb
    begin
        logic right;
        logic top;
        right = s3_reg.wrap_x && idx_reg[0];
        top   = s3_reg.wrap_y && (s3_reg.wrap_x ? idx_reg[1] : idx_reg[0]);

        piece_next.piece_level = s3_reg.level;
        piece_next.piece_west  = right ? s3_reg.seam_x_hi : s3_reg.uw;
        piece_next.piece_east  = (s3_reg.wrap_x && !right) ? s3_reg.seam_x_lo : s3_reg.ue;
        piece_next.piece_south = top ? s3_reg.seam_y_hi : s3_reg.us;
        piece_next.piece_north = (s3_reg.wrap_y && !top) ? s3_reg.seam_y_lo : s3_reg.un;
        piece_next.piece_last  = (idx_reg == last_idx);
    end

    // Stage valids, sequencer index and output strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            idx_reg         <= 2'd0;
            piece_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= start;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
                idx_reg      <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            piece_valid_reg <= s3_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= req;
        end
        if (s2_load)
        begin
            s2_reg <= s2_next;
        end
        if (s3_load)
        begin
            s3_reg <= s3_next;
        end
        piece_reg <= piece_next;
    end

    assign piece_valid = piece_valid_reg;
    assign piece       = piece_reg;

    // A piece that is not the last one is always followed by the next piece.
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && !piece.piece_last |=> piece_valid)
        else $error("wrapping update lost a piece");

    // The sequencer emits in every cycle that it holds an update.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |=> piece_valid)
        else $error("sequencer held an update without emitting");

    // The piece index never passes the final piece of the update.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> idx_reg <= last_idx)
        else $error("piece index beyond final piece");

    // busy is only raised while every front stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && !s3_last)
        else $error("busy raised with room in the pipeline");

    // An accepted request occupies the input stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> s1_valid_reg)
        else $error("accepted request not captured");

endmodule
